// ===== hw/rtl/olt_pkg.sv =====
package olt_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W = 3;
    localparam int ST_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
    localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
    localparam logic [OP_W-1:0] OP_FIND       = 3'd6;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd7;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    // match bits examined per scan cycle
    localparam int GRP_BITS   = 3;
    localparam int SCAN_GROUP = 1 << GRP_BITS;

    typedef struct packed {
        logic ins;  // open a slot at pos, write value there
        logic rem;  // close the slot at pos
        logic cmp;  // latch match against value
    } cell_ctrl_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_res_t;

endpackage

// ===== hw/rtl/ordered_list_table.sv =====
// channel | direction | handshake              | word
// cmd     | in        | cmd_valid / cmd_stall  | opcode, position, value
// rsp     | out       | rsp_valid / rsp_stall  | status, found, found_index, count
//
// Push, pop, insert, erase and clear complete on the accepting edge: the cell row
// shifts in parallel and the response is registered on the accepting edge.
// Find latches all cell compares on the accepting edge, then scans eight match
// bits per cycle and stops at the first group with a hit, or at the group that
// reaches past the live entries.
// Reset empties the list; cell contents are left as they are.
// cmd_stall is high during a find and while a response waits under rsp_stall.
module ordered_list_table #(
    parameter int DEPTH      = olt_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = olt_pkg::DATA_WIDTH_DEF,
    parameter int POS_W      = $clog2(DEPTH + 1),
    parameter int IDX_W      = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  logic [olt_pkg::OP_W-1:0]    opcode,
    input  logic [POS_W-1:0]            position,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output logic [olt_pkg::ST_W-1:0]    status,
    output logic                        found,
    output logic [IDX_W-1:0]            found_index,
    output logic [POS_W-1:0]            count
);
    import olt_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_FIND = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [POS_W-1:0]      entry_count_reg;
    logic [POS_W-1:0]      entry_count_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic [ST_W-1:0]       status_reg;
    logic [ST_W-1:0]       status_next;
    logic                  found_reg;
    logic                  found_next;
    logic [IDX_W-1:0]      found_index_reg;
    logic [IDX_W-1:0]      found_index_next;
    logic [POS_W-1:0]      count_reg;
    logic [POS_W-1:0]      count_next;

    logic                  acc;
    logic                  is_ins;
    logic                  is_rem;
    logic [POS_W-1:0]      pos_eff;
    logic [ST_W-1:0]       cmd_status;
    cell_ctrl_t            ctrl;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]      hits;
    scan_res_t             scan_res;
    logic [IDX_W-1:0]      scan_index;

    assign cmd_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign acc       = cmd_valid && !cmd_stall;

    always_comb
    begin
        is_ins     = 1'b0;
        is_rem     = 1'b0;
        pos_eff    = position;
        cmd_status = ST_OK;
        unique case (opcode)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT:
            begin
                if (opcode == OP_PUSH_BACK)
                    pos_eff = entry_count_reg;
                else if (opcode == OP_PUSH_FRONT)
                    pos_eff = '0;
                if (pos_eff > entry_count_reg)
                    cmd_status = ST_RANGE;
                else if (entry_count_reg >= POS_W'(DEPTH))
                    cmd_status = ST_FULL;
                else
                    is_ins = 1'b1;
            end
            OP_POP_BACK, OP_POP_FRONT, OP_ERASE:
            begin
                if (opcode == OP_POP_BACK)
                    pos_eff = entry_count_reg - POS_W'(1);
                else if (opcode == OP_POP_FRONT)
                    pos_eff = '0;
                if (entry_count_reg == '0)
                    cmd_status = ST_EMPTY;
                else if (pos_eff >= entry_count_reg)
                    cmd_status = ST_RANGE;
                else
                    is_rem = 1'b1;
            end
            OP_FIND, OP_CLEAR:
            begin
                cmd_status = ST_OK;
            end
            default:
            begin
                cmd_status = ST_OK;
            end
        endcase

        ctrl.ins = acc && is_ins;
        ctrl.rem = acc && is_rem;
        ctrl.cmp = acc && (opcode == OP_FIND);
    end

    generate
        for (genvar i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] left_w;
            logic [DATA_WIDTH-1:0] right_w;
            if (i == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_left
                assign left_w = cell_data[i-1];
            end
            if (i == DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_right
                assign right_w = cell_data[i+1];
            end

            olt_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .POS_W      (POS_W),
                .CELL_IDX   (i)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .pos        (pos_eff),
                .cnt        (entry_count_reg),
                .value      (value),
                .left_data  (left_w),
                .right_data (right_w),
                .data       (cell_data[i]),
                .hit        (hits[i])
            );
        end
    endgenerate

    olt_scan #(
        .DEPTH (DEPTH),
        .POS_W (POS_W),
        .IDX_W (IDX_W)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.cmp),
        .hits  (hits),
        .cnt   (entry_count_reg),
        .res   (scan_res),
        .index (scan_index)
    );

    always_comb
    begin
        state_next       = state_reg;
        entry_count_next = entry_count_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        status_next      = status_reg;
        found_next       = found_reg;
        found_index_next = found_index_reg;
        count_next       = count_reg;

        if (acc)
        begin
            if (opcode == OP_FIND)
            begin
                state_next = S_FIND;
            end
            else
            begin
                if (ctrl.ins)
                    entry_count_next = entry_count_reg + POS_W'(1);
                else if (ctrl.rem)
                    entry_count_next = entry_count_reg - POS_W'(1);
                else if (opcode == OP_CLEAR)
                    entry_count_next = '0;
                rsp_valid_next   = 1'b1;
                status_next      = cmd_status;
                found_next       = 1'b0;
                found_index_next = '0;
                count_next       = entry_count_next;
            end
        end
        else if (state_reg == S_FIND && scan_res.done)
        begin
            // the output word is free here: nothing else loads it during a find
            state_next       = S_IDLE;
            rsp_valid_next   = 1'b1;
            status_next      = ST_OK;
            found_next       = scan_res.found;
            found_index_next = scan_index;
            count_next       = entry_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            entry_count_reg <= entry_count_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        found_reg       <= found_next;
        found_index_reg <= found_index_next;
        count_reg       <= count_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign found_index = found_index_reg;
    assign count       = count_reg;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= POS_W'(DEPTH))
        else $error("entry count above capacity");

    a_plain_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (opcode != OP_FIND) |=> rsp_valid)
        else $error("no response after a one-cycle command");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found |-> (status == ST_OK) && (POS_W'(found_index) < count))
        else $error("find hit outside the list");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_count_reg != $past(entry_count_reg)) |-> $past(acc))
        else $error("entry count changed without a command");
`endif

endmodule

// ===== hw/rtl/olt_cell.sv =====
module olt_cell #(
    parameter int DATA_WIDTH = olt_pkg::DATA_WIDTH_DEF,
    parameter int POS_W      = 7,
    parameter int CELL_IDX   = 0
) (
    input  logic                   clk,
    input  olt_pkg::cell_ctrl_t    ctrl,
    input  logic [POS_W-1:0]       pos,
    input  logic [POS_W-1:0]       cnt,
    input  logic [DATA_WIDTH-1:0]  value,
    input  logic [DATA_WIDTH-1:0]  left_data,
    input  logic [DATA_WIDTH-1:0]  right_data,
    output logic [DATA_WIDTH-1:0]  data,
    output logic                   hit
);
    import olt_pkg::*;

    localparam logic [POS_W-1:0] IDX = POS_W'(CELL_IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic                  hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.ins)
        begin
            if (IDX == pos)
                data_reg <= value;
            else if (IDX > pos)
                data_reg <= left_data;
        end
        else if (ctrl.rem)
        begin
            // pull the right neighbor's word over the erased slot
            if (IDX >= pos)
                data_reg <= right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cmp)
            hit_reg <= (data_reg == value) && (IDX < cnt);
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

// ===== hw/rtl/olt_scan.sv =====
module olt_scan #(
    parameter int DEPTH = olt_pkg::DEPTH_DEF,
    parameter int POS_W = 7,
    parameter int IDX_W = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DEPTH-1:0]    hits,
    input  logic [POS_W-1:0]    cnt,
    output olt_pkg::scan_res_t  res,
    output logic [IDX_W-1:0]    index
);
    import olt_pkg::*;

    localparam int NGRP  = (DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int HIT_W = NGRP * SCAN_GROUP;
    localparam int END_W = GRP_W + 1 + GRP_BITS;

    logic                  busy_reg;
    logic                  busy_next;
    logic [GRP_W-1:0]      grp_reg;
    logic [GRP_W-1:0]      grp_next;
    logic [HIT_W-1:0]      hit_pad;
    logic [SCAN_GROUP-1:0] chunk;
    logic [GRP_BITS-1:0]   enc;
    logic [END_W-1:0]      grp_end;
    logic                  last;

    always_comb
    begin
        hit_pad = HIT_W'(hits);
        chunk   = hit_pad[grp_reg*SCAN_GROUP +: SCAN_GROUP];
        enc     = '0;
        for (int b = SCAN_GROUP - 1; b >= 0; b--)
        begin
            if (chunk[b])
                enc = GRP_BITS'(b);
        end
        grp_end = {(GRP_W + 1)'(grp_reg) + (GRP_W + 1)'(1), GRP_BITS'(0)};
        // stop once this group reaches past the live entries
        last    = (grp_end >= END_W'(cnt));

        res.found = busy_reg && (|chunk);
        res.done  = busy_reg && ((|chunk) || last);
        index     = (|chunk) ? IDX_W'({grp_reg, enc}) : '0;

        busy_next = busy_reg;
        grp_next  = grp_reg;
        if (start)
        begin
            busy_next = 1'b1;
            grp_next  = '0;
        end
        else if (busy_reg)
        begin
            if (res.done)
                busy_next = 1'b0;
            else
                grp_next = grp_reg + GRP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            grp_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            grp_reg  <= grp_next;
        end
    end

endmodule

// ===== tb/olt_list_checker.sv =====
module olt_list_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  logic                   cmd_stall,
    input  logic [olt_pkg::OP_W-1:0] opcode,
    input  logic [6:0]             position,
    input  logic signed [31:0]     value,
    input  logic                   rsp_valid,
    input  logic                   rsp_stall,
    input  logic [olt_pkg::ST_W-1:0] status,
    input  logic                   found,
    input  logic [5:0]             found_index,
    input  logic [6:0]             count,
    output int                     errors,
    output int                     pending,
    output int                     checked,
    output int                     rejected,
    output int                     hits
);
    import olt_pkg::*;

    localparam int CAPACITY = DEPTH_DEF;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic            found;
        logic [5:0]      found_index;
        logic [6:0]      count;
    } list_rsp_t;

    logic signed [31:0] list_mem [CAPACITY];
    int                 list_len = 0;
    list_rsp_t          rsp_due [$];
    int                 err_n = 0;
    int                 checked_n = 0;
    int                 rejected_n = 0;
    int                 hits_n = 0;

    function automatic list_rsp_t apply_cmd(input logic [OP_W-1:0] op,
                                            input logic [6:0] pos,
                                            input logic signed [31:0] val);
        list_rsp_t r;
        int        slot;
        int        i;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT:
            begin
                if (op == OP_PUSH_BACK)
                    slot = list_len;
                else if (op == OP_PUSH_FRONT)
                    slot = 0;
                else
                    slot = pos;
                // range check ranks above the full check
                if (slot > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > slot; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[slot] = val;
                    list_len++;
                end
            end
            OP_POP_BACK, OP_POP_FRONT, OP_ERASE:
            begin
                if (op == OP_POP_BACK)
                    slot = list_len - 1;
                else if (op == OP_POP_FRONT)
                    slot = 0;
                else
                    slot = pos;
                // empty check ranks above the range check
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (slot >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = slot; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            OP_FIND:
            begin
                for (i = 0; i < list_len; i++)
                begin
                    if (list_mem[i] == val)
                    begin
                        r.found = 1'b1;
                        r.found_index = i[5:0];
                        break;
                    end
                end
            end
            default:
                list_len = 0;
        endcase
        r.count = list_len[6:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_n++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_rsp_t exp_rsp;
        if (!rst_n)
        begin
            list_len = 0;
            rsp_due.delete();
        end
        else
        begin
            // match the outgoing word first: it answers an older command
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_due.size() == 0)
                begin
                    $display("%0t: response with none expected, actual status %0d count %0d",
                             $time, status, count);
                    err_n++;
                end
                else
                begin
                    exp_rsp = rsp_due.pop_front();
                    check_field("status", exp_rsp.status, status);
                    check_field("found", exp_rsp.found, found);
                    check_field("found_index", exp_rsp.found_index, found_index);
                    check_field("count", exp_rsp.count, count);
                    checked_n++;
                    if (exp_rsp.status != ST_OK)
                        rejected_n++;
                    if (exp_rsp.found)
                        hits_n++;
                end
            end
            if (cmd_valid && !cmd_stall)
                rsp_due.push_back(apply_cmd(opcode, position, value));
        end
        errors   <= err_n;
        pending  <= rsp_due.size();
        checked  <= checked_n;
        rejected <= rejected_n;
        hits     <= hits_n;
    end

endmodule

// ===== tb/tb_ordered_list_table.sv =====
module tb_ordered_list_table;
    import olt_pkg::*;

    localparam int RANDOM_CMDS = 1425;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 250;

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    logic [OP_W-1:0]     opcode;
    logic [6:0]          position;
    logic signed [31:0]  value;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [ST_W-1:0]     status;
    logic                found;
    logic [5:0]          found_index;
    logic [6:0]          count;

    int errors;
    int pending;
    int checked;
    int rejected;
    int hits;
    int cycles = 0;
    int cmds_sent = 0;
    bit tx_burst = 0;
    bit rx_burst = 0;

    logic signed [31:0] value_pool [8] = '{32'sd0, -32'sd1, 32'sh8000_0000, 32'sh7fff_ffff,
                                           32'sd1, 32'sd2, 32'sh5a5a_5a5a, 32'sha5a5_a5a5};

    ordered_list_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .opcode      (opcode),
        .position    (position),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .count       (count)
    );

    olt_list_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .opcode      (opcode),
        .position    (position),
        .value       (value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .found       (found),
        .found_index (found_index),
        .count       (count),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked),
        .rejected    (rejected),
        .hits        (hits)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
            $display("tb_ordered_list_table failed");
            $finish;
        end
    end

    // Keep valid high across back-to-back words; drop it only for a gap.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [6:0] pos,
                            input logic signed [31:0] val);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        opcode    <= op;
        position  <= pos;
        value     <= val;
        do
            @(posedge clk);
        while (cmd_stall);
        cmds_sent++;
    endtask

    function automatic logic [OP_W-1:0] pick_op(input int mode);
        int r;
        r = $urandom_range(0, 199);
        if (r == 0)
            return OP_CLEAR;
        r = r % 100;
        case (mode)
            0:  // grow toward full
            begin
                if (r < 28) return OP_PUSH_BACK;
                if (r < 52) return OP_PUSH_FRONT;
                if (r < 82) return OP_INSERT;
                if (r < 92) return OP_FIND;
                if (r < 95) return OP_POP_BACK;
                if (r < 97) return OP_POP_FRONT;
                return OP_ERASE;
            end
            1:  // drain toward empty
            begin
                if (r < 28) return OP_POP_BACK;
                if (r < 52) return OP_POP_FRONT;
                if (r < 82) return OP_ERASE;
                if (r < 92) return OP_FIND;
                if (r < 95) return OP_PUSH_BACK;
                if (r < 97) return OP_PUSH_FRONT;
                return OP_INSERT;
            end
            2:  // search heavy
            begin
                if (r < 50) return OP_FIND;
                if (r < 60) return OP_PUSH_BACK;
                if (r < 70) return OP_PUSH_FRONT;
                if (r < 80) return OP_INSERT;
                if (r < 87) return OP_POP_BACK;
                if (r < 94) return OP_POP_FRONT;
                return OP_ERASE;
            end
            default:
                return OP_W'($urandom_range(0, 6));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 9) < 6)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [6:0] pick_pos();
        if ($urandom_range(0, 9) == 0)
            return 7'($urandom_range(0, 127));
        return 7'($urandom_range(0, $urandom_range(0, 64)));
    endfunction

    // receiver: random hold before each word, bursts without holds, two long holds
    initial
    begin
        int hold;
        int taken;
        taken = 0;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            hold = rx_burst ? 0 : $urandom_range(0, 15);
            if (taken == 300 || taken == 1000)
                hold = LONG_HOLD;
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
            taken++;
        end
    end

    initial
    begin
        int mode;
        int phase_left;
        int n;
        cmd_valid <= 1'b0;
        opcode    <= OP_PUSH_BACK;
        position  <= '0;
        value     <= '0;
        rst_n     <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_cmd(OP_CLEAR,      7'd0,   32'sd0);
        send_cmd(OP_POP_BACK,   7'd0,   32'sd0);
        send_cmd(OP_POP_FRONT,  7'd0,   32'sd0);
        send_cmd(OP_ERASE,      7'd0,   32'sd0);
        // empty wins over a bad position
        send_cmd(OP_ERASE,      7'd127, 32'sd0);
        send_cmd(OP_FIND,       7'd0,   32'sd0);
        send_cmd(OP_PUSH_BACK,  7'd0,   32'sh7fff_ffff);
        send_cmd(OP_PUSH_FRONT, 7'd0,   32'sh8000_0000);
        send_cmd(OP_INSERT,     7'd1,   -32'sd1);
        send_cmd(OP_INSERT,     7'd4,   32'sd5);
        send_cmd(OP_INSERT,     7'd127, 32'sd5);
        // insert at the count appends
        send_cmd(OP_INSERT,     7'd3,   32'sd0);
        send_cmd(OP_ERASE,      7'd4,   32'sd0);
        send_cmd(OP_ERASE,      7'd64,  32'sd0);
        send_cmd(OP_FIND,       7'd0,   -32'sd1);
        send_cmd(OP_FIND,       7'd0,   32'sd0);
        send_cmd(OP_FIND,       7'd0,   32'sd12345);
        send_cmd(OP_PUSH_BACK,  7'd0,   -32'sd1);
        // duplicate value: first index wins
        send_cmd(OP_FIND,       7'd0,   -32'sd1);
        send_cmd(OP_ERASE,      7'd1,   32'sd0);
        send_cmd(OP_POP_BACK,   7'd0,   32'sd0);
        send_cmd(OP_POP_FRONT,  7'd0,   32'sd0);
        send_cmd(OP_CLEAR,      7'd0,   32'sd0);
        // cleared entries keep their bits but must not match
        send_cmd(OP_FIND,       7'd0,   32'sh7fff_ffff);

        phase_left = 0;
        mode = 0;
        for (n = 0; n < RANDOM_CMDS; n++)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(30, 120);
                mode = $urandom_range(0, 3);
                tx_burst = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            send_cmd(pick_op(mode), pick_pos(), pick_value());
        end
        cmd_valid <= 1'b0;

        // let the last accepted word reach the expectation queue
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d commands, %0d responses compared", cmds_sent, checked);
        $display("rejected as full, empty or out of range: %0d, finds that matched: %0d",
                 rejected, hits);
        if (errors == 0 && pending == 0)
            $display("tb_ordered_list_table passed");
        else
            $display("tb_ordered_list_table failed");
        $finish;
    end

endmodule
